// File: design/bpc_pkg.sv
// Shared constants, types and the window decode function of the bus patch code unit.
`default_nettype none

package bpc_pkg;

	localparam int NUM_SLOTS = 5;
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [21:0] ENABLE_ADDR = 22'h000002;
	localparam logic [15:0] ENABLE_KEY = 16'h0001;
	localparam logic [21:0] WIN_LO = 22'h000004;
	localparam logic [21:0] WIN_HI = 22'h000020;

	localparam logic [1:0] ROUTE_PATCH = 2'd0;
	localparam logic [1:0] ROUTE_CART = 2'd1;
	localparam logic [1:0] ROUTE_ROM = 2'd2;
	localparam logic [1:0] ROUTE_ABSORB = 2'd3;

	localparam logic [1:0] WORD_ADDR_HI = 2'd0;
	localparam logic [1:0] WORD_ADDR_LO = 2'd1;
	localparam logic [1:0] WORD_DATA = 2'd2;

	typedef struct packed {
		logic [2:0] slot;
		logic [1:0] word;
	} win_pos_t;

	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] slot;
		logic [1:0] word;
		logic [15:0] data;
	} prog_t;

	typedef struct packed {
		logic hit;
		logic [15:0] data;
	} match_t;

	// Splits the word number within the programming window into slot and word.
	function automatic win_pos_t win_decode(input logic [3:0] k);
		win_pos_t p;
		case (k)
			4'd0: p = '{slot: 3'd0, word: WORD_ADDR_HI};
			4'd1: p = '{slot: 3'd0, word: WORD_ADDR_LO};
			4'd2: p = '{slot: 3'd0, word: WORD_DATA};
			4'd3: p = '{slot: 3'd1, word: WORD_ADDR_HI};
			4'd4: p = '{slot: 3'd1, word: WORD_ADDR_LO};
			4'd5: p = '{slot: 3'd1, word: WORD_DATA};
			4'd6: p = '{slot: 3'd2, word: WORD_ADDR_HI};
			4'd7: p = '{slot: 3'd2, word: WORD_ADDR_LO};
			4'd8: p = '{slot: 3'd2, word: WORD_DATA};
			4'd9: p = '{slot: 3'd3, word: WORD_ADDR_HI};
			4'd10: p = '{slot: 3'd3, word: WORD_ADDR_LO};
			4'd11: p = '{slot: 3'd3, word: WORD_DATA};
			4'd12: p = '{slot: 3'd4, word: WORD_ADDR_HI};
			4'd13: p = '{slot: 3'd4, word: WORD_ADDR_LO};
			4'd14: p = '{slot: 3'd4, word: WORD_DATA};
			default: p = '{slot: 3'd7, word: WORD_DATA};
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: design/bpc_slot_bank.sv
// Code slot storage with programming writes and prioritized address match.
`default_nettype none

module bpc_slot_bank (
	input wire logic clk,
	input wire logic arst_n,
	input wire bpc_pkg::prog_t prog,
	input wire logic [21:0] lookup_addr,
	output bpc_pkg::match_t match
);

	logic [bpc_pkg::NUM_SLOTS-1:0] armed_q;
	logic [23:0] addr_q [bpc_pkg::NUM_SLOTS];
	logic [15:0] data_q [bpc_pkg::NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (prog.en && prog.word == bpc_pkg::WORD_DATA) begin
			armed_q[prog.slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bpc_pkg::NUM_SLOTS; i++) begin
				addr_q[i] <= '0;
				data_q[i] <= '0;
			end
		end else if (prog.en) begin
			case (prog.word)
				bpc_pkg::WORD_ADDR_HI: addr_q[prog.slot][23:16] <= prog.data[7:0];
				bpc_pkg::WORD_ADDR_LO: addr_q[prog.slot][15:0] <= prog.data;
				bpc_pkg::WORD_DATA: data_q[prog.slot] <= prog.data;
				default: ;
			endcase
		end
	end

	// The lowest-numbered matching slot wins, so scan from the top down.
	always_comb begin
		match = '0;
		for (int i = bpc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (armed_q[i] && addr_q[i] == {2'b00, lookup_addr}) begin
				match.hit = 1'b1;
				match.data = data_q[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/bus_patch_code_unit.sv
// Top level of the bus patch code unit: input stage, routing decode and result register.
`default_nettype none

// Each bus access beat is held in the input register and then in the result
// register; it moves into the result register once that register is empty or
// its result is taken, and a new access is accepted every cycle while results
// are taken. Writes that program slots or the enable register take effect
// before the following access is decoded. The cartridge_connected register is
// written through the cfg channel, which is always ready.
module bus_patch_code_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cartridge_connected,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic req_type,
	input wire logic [21:0] bus_address,
	input wire logic [15:0] write_data,
	input wire logic upper_strobe,
	input wire logic lower_strobe,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] route,
	output logic [15:0] read_data,
	output logic [20:0] rom_word_index
);

	logic cart_q;
	logic enabled_q;

	logic valid_s1;
	logic req_s1;
	logic [21:0] addr_s1;
	logic [15:0] data_s1;
	logic up_s1;
	logic lo_s1;

	logic valid_s2;
	logic [1:0] route_s2;
	logic [15:0] rdata_s2;
	logic [20:0] rom_s2;

	logic advance;
	logic absorb;
	logic [3:0] win_k;
	bpc_pkg::win_pos_t win_pos;
	bpc_pkg::prog_t prog;
	bpc_pkg::match_t match;
	logic [1:0] route_d;
	logic [15:0] rdata_d;
	logic [20:0] rom_d;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_q <= 1'b0;
		end else if (cfg_valid) begin
			cart_q <= cartridge_connected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_type;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
			up_s1 <= upper_strobe;
			lo_s1 <= lower_strobe;
		end
	end

	assign absorb = req_s1 && !(enabled_q && cart_q);
	assign win_k = 4'(6'(addr_s1[5:0] - 6'd4) >> 1);
	assign win_pos = bpc_pkg::win_decode(win_k);

	always_comb begin
		prog.en = advance && absorb && up_s1 && lo_s1
			&& addr_s1 >= bpc_pkg::WIN_LO && addr_s1 <= bpc_pkg::WIN_HI
			&& win_pos.slot < 3'(bpc_pkg::NUM_SLOTS);
		prog.slot = win_pos.slot[bpc_pkg::SLOT_W-1:0];
		prog.word = win_pos.word;
		prog.data = data_s1;
	end

	bpc_slot_bank u_slot_bank (
		.clk(clk),
		.arst_n(arst_n),
		.prog(prog),
		.lookup_addr(addr_s1),
		.match(match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (advance && absorb && addr_s1 == bpc_pkg::ENABLE_ADDR
				&& data_s1 == bpc_pkg::ENABLE_KEY) begin
			enabled_q <= 1'b1;
		end
	end

	always_comb begin
		rdata_d = '0;
		rom_d = '0;
		if (!req_s1) begin
			route_d = bpc_pkg::ROUTE_ROM;
			if (enabled_q && match.hit) begin
				route_d = bpc_pkg::ROUTE_PATCH;
				rdata_d = match.data;
			end else if (enabled_q && cart_q) begin
				route_d = bpc_pkg::ROUTE_CART;
			end else begin
				rom_d = addr_s1[21:1];
			end
		end else if (absorb) begin
			route_d = bpc_pkg::ROUTE_ABSORB;
		end else begin
			route_d = bpc_pkg::ROUTE_CART;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			route_s2 <= route_d;
			rdata_s2 <= rdata_d;
			rom_s2 <= rom_d;
		end
	end

	assign out_valid = valid_s2;
	assign route = route_s2;
	assign read_data = rdata_s2;
	assign rom_word_index = rom_s2;

endmodule

`default_nettype wire

// File: tb/sv/bus_patch_code_checker.sv
// Checker for the bus patch code unit: tracks slot state, predicts each result and compares.
`timescale 1ns / 1ps

module bus_patch_code_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic cartridge_connected,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic req_type,
	input wire logic [21:0] bus_address,
	input wire logic [15:0] write_data,
	input wire logic upper_strobe,
	input wire logic lower_strobe,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] route,
	input wire logic [15:0] read_data,
	input wire logic [20:0] rom_word_index,
	output int fail_count,
	output int pending,
	output int results_seen,
	output int patched_reads
);

	typedef struct packed {
		logic [1:0] route;
		logic [15:0] read_data;
		logic [20:0] rom_word_index;
	} bus_result_t;

	logic unit_on;
	logic cart_on;
	logic slot_armed [bpc_pkg::NUM_SLOTS];
	logic [23:0] slot_addr [bpc_pkg::NUM_SLOTS];
	logic [15:0] slot_data [bpc_pkg::NUM_SLOTS];
	bus_result_t pending_routes [$];
	bus_result_t want;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (fail_count < 200)
			$display("mismatch at %0t ns: %s, got %h, wanted %h", $time, what, got, exp_val);
		fail_count = fail_count + 1;
	endtask

	function automatic bus_result_t decode_access(input logic is_write, input logic [21:0] addr,
		input logic [15:0] data, input logic up, input logic lo);
		bus_result_t r;
		logic hit;
		logic [21:0] offset;
		logic [4:0] k;
		logic [1:0] w;
		int s;
		int i;
		r.route = bpc_pkg::ROUTE_ROM;
		r.read_data = '0;
		r.rom_word_index = '0;
		hit = 1'b0;
		if (!is_write) begin
			if (unit_on) begin
				for (i = 0; i < bpc_pkg::NUM_SLOTS; i++) begin
					if (!hit && slot_armed[i] && slot_addr[i] == {2'b00, addr}) begin
						hit = 1'b1;
						r.read_data = slot_data[i];
					end
				end
				if (hit)
					r.route = bpc_pkg::ROUTE_PATCH;
				else if (cart_on)
					r.route = bpc_pkg::ROUTE_CART;
			end
			if (r.route == bpc_pkg::ROUTE_ROM)
				r.rom_word_index = addr[21:1];
		end else if (unit_on && cart_on) begin
			r.route = bpc_pkg::ROUTE_CART;
		end else begin
			r.route = bpc_pkg::ROUTE_ABSORB;
			if (addr == bpc_pkg::ENABLE_ADDR && data == bpc_pkg::ENABLE_KEY)
				unit_on = 1'b1;
			if (addr >= bpc_pkg::WIN_LO && addr <= bpc_pkg::WIN_HI && up && lo) begin
				offset = addr - bpc_pkg::WIN_LO;
				k = offset[5:1];
				s = int'(k) / 3;
				w = 2'(int'(k) % 3);
				if (s < bpc_pkg::NUM_SLOTS) begin
					case (w)
						bpc_pkg::WORD_ADDR_HI: slot_addr[s][23:16] = data[7:0];
						bpc_pkg::WORD_ADDR_LO: slot_addr[s][15:0] = data;
						default: begin
							slot_data[s] = data;
							slot_armed[s] = 1'b1;
						end
					endcase
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_on = 1'b0;
			cart_on = 1'b0;
			for (int i = 0; i < bpc_pkg::NUM_SLOTS; i++) begin
				slot_armed[i] = 1'b0;
				slot_addr[i] = '0;
				slot_data[i] = '0;
			end
			pending_routes.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			patched_reads = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cart_on = cartridge_connected;
			if (out_valid && out_ready) begin
				if (pending_routes.size() == 0) begin
					report_mismatch("result beat with no access pending", int'(route), 0);
				end else begin
					want = pending_routes.pop_front();
					if (route !== want.route)
						report_mismatch("route", int'(route), int'(want.route));
					if (read_data !== want.read_data)
						report_mismatch("read_data", int'(read_data), int'(want.read_data));
					if (rom_word_index !== want.rom_word_index)
						report_mismatch("rom_word_index", int'(rom_word_index),
							int'(want.rom_word_index));
					results_seen = results_seen + 1;
					if (want.route == bpc_pkg::ROUTE_PATCH)
						patched_reads = patched_reads + 1;
				end
			end
			if (in_valid && in_ready)
				pending_routes.push_back(decode_access(req_type, bus_address, write_data,
					upper_strobe, lower_strobe));
			pending = pending_routes.size();
		end
	end

endmodule

// File: tb/sv/tb_bus_patch_code_unit.sv
// Testbench top for the bus patch code unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_bus_patch_code_unit;

	localparam logic REQ_READ = 1'b0;
	localparam logic REQ_WRITE = 1'b1;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 232;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cartridge_connected;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [21:0] bus_address;
	logic [15:0] write_data;
	logic upper_strobe;
	logic lower_strobe;
	logic out_valid;
	logic out_ready;
	logic [1:0] route;
	logic [15:0] read_data;
	logic [20:0] rom_word_index;

	int fail_count;
	int pending;
	int results_seen;
	int patched_reads;
	int sent_items;
	int cart_phases;
	int stall_cycles;
	logic quiet;
	logic [23:0] code_addr [8];

	bus_patch_code_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cartridge_connected(cartridge_connected),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.bus_address(bus_address),
		.write_data(write_data),
		.upper_strobe(upper_strobe),
		.lower_strobe(lower_strobe),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.route(route),
		.read_data(read_data),
		.rom_word_index(rom_word_index)
	);

	bus_patch_code_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cartridge_connected(cartridge_connected),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.bus_address(bus_address),
		.write_data(write_data),
		.upper_strobe(upper_strobe),
		.lower_strobe(lower_strobe),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.route(route),
		.read_data(read_data),
		.rom_word_index(rom_word_index),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.patched_reads(patched_reads)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a beat", stall_cycles);
			$display("FAIL bus_patch_code_unit");
			$finish;
		end
	end

	function automatic logic [23:0] pick_code_address();
		logic [23:0] a;
		a = 24'($urandom);
		if ($urandom_range(3) != 0)
			a[23:22] = 2'b00;
		return a;
	endfunction

	task automatic send_access(input logic wr, input logic [21:0] addr, input logic [15:0] data,
		input logic up, input logic lo);
		while (!quiet && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= wr;
		bus_address <= addr;
		write_data <= data;
		upper_strobe <= up;
		lower_strobe <= lo;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent_items = sent_items + 1;
	endtask

	task automatic program_slot(input int slot, input logic [15:0] hi_word,
		input logic [15:0] lo_word, input logic [15:0] patch);
		logic [21:0] base;
		base = 22'(int'(bpc_pkg::WIN_LO) + slot * 6);
		send_access(REQ_WRITE, base, hi_word, 1'b1, 1'b1);
		send_access(REQ_WRITE, base + 22'd2, lo_word, 1'b1, 1'b1);
		send_access(REQ_WRITE, base + 22'd4, patch, 1'b1, 1'b1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_cartridge(input logic present);
		cfg_valid <= 1'b1;
		cartridge_connected <= present;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cart_phases = cart_phases + 1;
	endtask

	initial begin
		int phase;
		int count;
		int pick;
		int idx;
		int slot;
		logic [15:0] hi_word;
		logic [15:0] data;
		logic [21:0] addr;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cartridge_connected = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_READ;
		bus_address = '0;
		write_data = '0;
		upper_strobe = 1'b0;
		lower_strobe = 1'b0;
		out_ready = 1'b0;
		quiet = 1'b0;
		sent_items = 0;
		cart_phases = 0;
		stall_cycles = 0;
		for (int i = 0; i < 8; i++)
			code_addr[i] = pick_code_address();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_cartridge(1'b1);
		send_access(REQ_READ, 22'h000000, 16'h0000, 1'b0, 1'b0);
		send_access(REQ_READ, 22'h3FFFFF, 16'hFFFF, 1'b1, 1'b1);
		program_slot(0, 16'h0012, 16'h3456, 16'hFFFF);
		send_access(REQ_READ, 22'h123456, 16'h0000, 1'b1, 1'b1);

		wait_idle();
		write_cartridge(1'b0);
		send_access(REQ_WRITE, 22'h00000A, 16'h00AB, 1'b1, 1'b0);
		send_access(REQ_WRITE, 22'h00000B, 16'h0012, 1'b1, 1'b1);
		send_access(REQ_WRITE, 22'h00000C, 16'h3456, 1'b1, 1'b1);
		send_access(REQ_WRITE, 22'h00000E, 16'h0000, 1'b1, 1'b1);
		program_slot(2, 16'h00C0, 16'h0000, 16'hBEEF);
		send_access(REQ_WRITE, bpc_pkg::ENABLE_ADDR, 16'h0002, 1'b1, 1'b1);
		send_access(REQ_READ, 22'h123456, 16'h0000, 1'b0, 1'b0);
		send_access(REQ_WRITE, bpc_pkg::ENABLE_ADDR, bpc_pkg::ENABLE_KEY, 1'b0, 1'b0);
		send_access(REQ_READ, 22'h123456, 16'h0000, 1'b0, 1'b0);
		send_access(REQ_READ, 22'h000000, 16'h0000, 1'b0, 1'b0);
		program_slot(bpc_pkg::NUM_SLOTS - 1, 16'hFF00, 16'h0000, 16'h7777);
		send_access(REQ_READ, 22'h000000, 16'h0000, 1'b0, 1'b0);
		send_access(REQ_WRITE, 22'h00001A, 16'h5555, 1'b1, 1'b1);
		send_access(REQ_READ, 22'h000000, 16'h0000, 1'b0, 1'b0);

		wait_idle();
		write_cartridge(1'b1);
		send_access(REQ_READ, 22'h000100, 16'h0000, 1'b0, 1'b0);
		send_access(REQ_WRITE, bpc_pkg::WIN_LO, 16'h0000, 1'b1, 1'b1);
		send_access(REQ_READ, 22'h123456, 16'h0000, 1'b0, 1'b0);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			write_cartridge(1'(phase % 2));
			quiet = (phase == 3);
			count = 0;
			while (count < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				idx = $urandom_range(7);
				data = 16'($urandom);
				if ($urandom_range(49) == 0)
					code_addr[$urandom_range(7)] = pick_code_address();
				if (pick < 30) begin
					slot = $urandom_range(bpc_pkg::NUM_SLOTS - 1);
					hi_word = 16'($urandom);
					hi_word[7:0] = code_addr[idx][23:16];
					program_slot(slot, hi_word, code_addr[idx][15:0], data);
					count += 3;
				end else if (pick < 70) begin
					send_access(REQ_READ, code_addr[idx][21:0], data, 1'($urandom_range(1)),
						1'($urandom_range(1)));
					count += 1;
				end else if (pick < 80) begin
					send_access(REQ_READ, 22'($urandom), data, 1'($urandom_range(1)),
						1'($urandom_range(1)));
					count += 1;
				end else if (pick < 93) begin
					if ($urandom_range(1) == 0)
						addr = 22'($urandom_range(int'(bpc_pkg::WIN_HI) + 3));
					else
						addr = 22'($urandom);
					send_access(REQ_WRITE, addr, data, 1'($urandom_range(1)),
						1'($urandom_range(1)));
					count += 1;
				end else begin
					if ($urandom_range(1) == 0)
						data = bpc_pkg::ENABLE_KEY;
					send_access(REQ_WRITE, bpc_pkg::ENABLE_ADDR, data, 1'($urandom_range(1)),
						1'($urandom_range(1)));
					count += 1;
				end
			end
		end
		quiet = 1'b0;

		wait_idle();
		repeat (8) @(negedge clk);
		$display("Run covered %0d bus accesses over %0d cartridge settings.",
			sent_items, cart_phases);
		$display("Checked %0d results, %0d of them patched reads.", results_seen, patched_reads);
		if (fail_count == 0)
			$display("PASS bus_patch_code_unit");
		else
			$display("FAIL bus_patch_code_unit");
		$finish;
	end

endmodule
